// ===== src/sacl_pkg.sv =====
`default_nettype none
package sacl_pkg;

    localparam int ADDR_W       = 32;
    localparam int TAG_W        = 32;
    localparam int CFG_W        = 4;
    localparam int CFG_INDEX_W  = 1;
    localparam int QUEUE_DEPTH  = 2;

    localparam int DEFAULT_MAX_SETS = 1024;
    localparam int DEFAULT_WAYS     = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_BITS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_BITS  = 1'd1;

    localparam logic [CFG_W-1:0] OFFSET_BITS_RESET = 4'd6;
    localparam logic [CFG_W-1:0] INDEX_BITS_RESET  = 4'd10;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_STORE = 1'b1;

    typedef struct packed {
        logic hit;
        logic writeback;
    } res_t;

endpackage
`default_nettype wire

// ===== src/sacl_ram.sv =====
`default_nettype none
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== src/sacl_queue.sv =====
`default_nettype none
module sacl_queue #(
    parameter int W     = 8,
    parameter int DEPTH = sacl_pkg::QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    input  wire logic         pop,
    output logic              full,
    output logic              empty,
    output logic      [W-1:0] pop_data
);

    logic [W-1:0]     entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== src/sacl_front.sv =====
`default_nettype none
module sacl_front #(
    parameter int MAX_SETS = sacl_pkg::DEFAULT_MAX_SETS,
    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
    localparam int INDEX_LIM = $clog2(MAX_SETS + 1) - 1
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [sacl_pkg::ADDR_W-1:0]       addr,
    input  wire logic                              cmd,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sacl_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [sacl_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                              q_full,
    input  wire logic                              clear_busy,
    output logic                                   push,
    output logic      [SET_W-1:0]                  push_set,
    output logic      [sacl_pkg::TAG_W-1:0]        push_tag,
    output logic                                   push_store
);

    logic [sacl_pkg::CFG_W-1:0]  offset_bits_reg;
    logic [sacl_pkg::CFG_W-1:0]  index_bits_reg;
    logic [sacl_pkg::CFG_W-1:0]  index_w;
    logic [sacl_pkg::ADDR_W-1:0] set_full;
    logic [sacl_pkg::CFG_W:0]    tag_shift;

    assign cfg_ready = 1'b1;
    assign in_stall  = clear_busy || q_full;
    assign push      = in_valid && !in_stall;

    assign index_w = (int'(index_bits_reg) > INDEX_LIM)
                   ? sacl_pkg::CFG_W'(INDEX_LIM) : index_bits_reg;
    assign set_full   = (addr >> offset_bits_reg)
                      & ((sacl_pkg::ADDR_W'(1) << index_w) - sacl_pkg::ADDR_W'(1));
    assign tag_shift  = {1'b0, offset_bits_reg} + {1'b0, index_w};
    assign push_set   = set_full[SET_W-1:0];
    assign push_tag   = sacl_pkg::TAG_W'(addr >> tag_shift);
    assign push_store = (cmd == sacl_pkg::CMD_STORE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= sacl_pkg::OFFSET_BITS_RESET;
            index_bits_reg  <= sacl_pkg::INDEX_BITS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sacl_pkg::CFG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                sacl_pkg::CFG_INDEX_BITS:  index_bits_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== src/sacl_back.sv =====
`default_nettype none
module sacl_back #(
    parameter int MAX_SETS = sacl_pkg::DEFAULT_MAX_SETS,
    parameter int WAYS     = sacl_pkg::DEFAULT_WAYS,
    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
    localparam int LINE_W = sacl_pkg::TAG_W + 2,
    localparam int ROW_W  = WAYS * LINE_W + 1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_valid,
    input  wire logic [SET_W-1:0]           q_set,
    input  wire logic [sacl_pkg::TAG_W-1:0] q_tag,
    input  wire logic                       q_store,
    output logic                            pop,
    output logic                            clear_busy,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output sacl_pkg::res_t                  res
);

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOK} state_t;

    state_t                     state_reg;
    logic [SET_W-1:0]           clr_cnt_reg;
    logic [SET_W-1:0]           set_reg;
    logic [sacl_pkg::TAG_W-1:0] tag_reg;
    logic                       store_reg;
    logic                       out_valid_reg, out_valid_next;
    sacl_pkg::res_t             res_reg;

    logic                       ram_we, ram_re;
    logic [SET_W-1:0]           ram_waddr;
    logic [ROW_W-1:0]           ram_wdata, row_old, row_new;
    logic                       slot_free;
    logic                       hit_any, wb;
    logic                       hit_way, victim, use_way;
    logic [WAYS-1:0]            way_hit;

    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (q_set),
        .rdata (row_old)
    );

    assign slot_free  = !out_valid_reg || !out_stall;
    assign clear_busy = (state_reg == ST_CLEAR);
    assign ram_re     = (state_reg == ST_IDLE) && q_valid;
    assign pop        = ram_re;
    assign ram_we     = clear_busy || ((state_reg == ST_LOOK) && slot_free);
    assign ram_waddr  = clear_busy ? clr_cnt_reg : set_reg;
    assign ram_wdata  = clear_busy ? '0 : row_new;
    assign out_valid  = out_valid_reg;
    assign res        = res_reg;

    assign out_valid_next = ((state_reg == ST_LOOK) && slot_free)
                         || (out_valid_reg && out_stall);

    always_comb
    begin
        hit_any = 1'b0;
        hit_way = 1'b0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            way_hit[w] = row_old[w*LINE_W + LINE_W - 1]
                      && (row_old[w*LINE_W +: sacl_pkg::TAG_W] == tag_reg);
            if (way_hit[w])
            begin
                hit_any = 1'b1;
                hit_way = 1'(w);
            end
        end
        victim  = (WAYS > 1) ? row_old[ROW_W-1] : 1'b0;
        use_way = hit_any ? hit_way : victim;
        wb      = !hit_any
               && row_old[int'(victim)*LINE_W + LINE_W - 1]
               && row_old[int'(victim)*LINE_W + LINE_W - 2];
        row_new = row_old;
        if (hit_any)
        begin
            if (store_reg)
            begin
                row_new[int'(hit_way)*LINE_W + LINE_W - 2] = 1'b1;
            end
        end
        else
        begin
            row_new[int'(victim)*LINE_W +: LINE_W] = {1'b1, store_reg, tag_reg};
        end
        row_new[ROW_W-1] = 1'(WAYS - 1 - int'(use_way));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == SET_W'(MAX_SETS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK:
                begin
                    if (slot_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            set_reg   <= q_set;
            tag_reg   <= q_tag;
            store_reg <= q_store;
        end
        if ((state_reg == ST_LOOK) && slot_free)
        begin
            res_reg.hit       <= hit_any;
            res_reg.writeback <= wb;
        end
    end

endmodule
`default_nettype wire

// ===== src/set_assoc_writeback_cache_lookup.sv =====
// Two-way set-associative write-back cache lookup with one LRU bit per set.
// Input channel (in_valid/in_stall): one access per transfer, addr and cmd
// (load or store). Output channel (out_valid/out_stall): one transfer per
// access, hit and writeback, in access order.
// Configuration channel (cfg_valid/cfg_ready): cfg_index 0 sets the block
// offset width, 1 sets the set index width; write only while idle.
// A front stage splits the address and queues the access; a back stage does
// a read-modify-write of the set's row in a one-read, one-write port RAM.
// Each access is queued, its set row is read into the RAM output register,
// and hit and writeback are registered once the output slot is free.
// The back stage pops no new access until the last set row is written.
// Reset: in_stall stays high for MAX_SETS cycles while every set row is
// cleared; configuration writes are taken during that sweep.
// Output stall: the result register holds; up to QUEUE_DEPTH + 1 further
// accesses are taken before in_stall rises.
`default_nettype none
module set_assoc_writeback_cache_lookup #(
    parameter int MAX_SETS = sacl_pkg::DEFAULT_MAX_SETS,
    parameter int WAYS     = sacl_pkg::DEFAULT_WAYS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [sacl_pkg::ADDR_W-1:0]       addr,
    input  wire logic                              cmd,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   hit,
    output logic                                   writeback,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sacl_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [sacl_pkg::CFG_W-1:0]        cfg_data
);

    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int Q_W   = 1 + sacl_pkg::TAG_W + SET_W;

    logic                       push, push_store, q_full, q_empty, pop, clear_busy;
    logic [SET_W-1:0]           push_set;
    logic [sacl_pkg::TAG_W-1:0] push_tag;
    logic [Q_W-1:0]             q_data;
    sacl_pkg::res_t             res;

    sacl_front #(
        .MAX_SETS (MAX_SETS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .addr       (addr),
        .cmd        (cmd),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .clear_busy (clear_busy),
        .push       (push),
        .push_set   (push_set),
        .push_tag   (push_tag),
        .push_store (push_store)
    );

    sacl_queue #(
        .W     (Q_W),
        .DEPTH (sacl_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_store, push_tag, push_set}),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .pop_data  (q_data)
    );

    sacl_back #(
        .MAX_SETS (MAX_SETS),
        .WAYS     (WAYS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (!q_empty),
        .q_set      (q_data[SET_W-1:0]),
        .q_tag      (q_data[SET_W +: sacl_pkg::TAG_W]),
        .q_store    (q_data[Q_W-1]),
        .pop        (pop),
        .clear_busy (clear_busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .res        (res)
    );

    assign hit       = res.hit;
    assign writeback = res.writeback;

    assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> in_stall)
        else $error("access taken during row clear");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clear_busy) |-> q_empty)
        else $error("queue not empty after row clear");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && writeback))
        else $error("writeback reported on a hit");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty && !clear_busy)
        else $error("pop from empty queue or during clear");

endmodule
`default_nettype wire
